@@ hdl/gsp_pkg.sv @@
// Shared types and constants for the GSM 7-bit septet pack/unpack unit.
// No dependencies.
package gsp_pkg;

    localparam int unsigned QueueDepth = 2;

    localparam logic [6:0] SeptetMask = 7'h7f;
    localparam logic [2:0] PosLastUnpack = 3'd6;
    localparam logic [2:0] PosInvalidUnpack = 3'd7;

    localparam logic ModePack = 1'b0;
    localparam logic ModeUnpack = 1'b1;

    // one queue entry: the results caused by one input item
    typedef struct packed {
        logic [7:0] data0;
        logic [7:0] data1;
        logic       two;
        logic       last;
    } t_entry;

endpackage

@@ hdl/gsp_front.sv @@
// Front end: takes input items, keeps group position and carry bits, and
// turns an item with results into a queue entry of up to two. Uses gsp_pkg.
module gsp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_accept,
    input  logic [7:0]        i_data_in,
    input  logic              i_last_item,
    output logic              o_push,
    output gsp_pkg::t_entry   o_entry
);

    logic       r_mode;
    logic [2:0] r_pos;
    logic [6:0] r_carry;
    logic [2:0] n_pos;
    logic [6:0] n_carry;

    logic [6:0]  w_char;
    logic [15:0] w_pack_wide;
    logic [7:0]  w_pack_oct;
    logic [6:0]  w_pack_carry;
    logic [2:0]  w_pack_pos;
    logic [2:0]  w_up_pos;
    logic [6:0]  w_up_carry_in;
    logic [15:0] w_up_wide;
    logic [6:0]  w_up_char;
    logic [6:0]  w_up_carry;
    logic        w_has0;
    logic        w_has1;

    assign w_char       = i_data_in[6:0] & gsp_pkg::SeptetMask;
    assign w_pack_wide  = {9'd0, w_char} << (4'd8 - {1'b0, r_pos});
    assign w_pack_oct   = w_pack_wide[7:0] | {1'b0, r_carry};
    assign w_pack_carry = w_char >> r_pos;
    assign w_pack_pos   = r_pos + 3'd1;

    // a stale position of 7 in unpack mode restarts the group
    assign w_up_pos      = (r_pos == gsp_pkg::PosInvalidUnpack) ? 3'd0 : r_pos;
    assign w_up_carry_in = (r_pos == gsp_pkg::PosInvalidUnpack) ? 7'd0 : r_carry;
    assign w_up_wide     = {8'd0, i_data_in} << w_up_pos;
    assign w_up_char     = w_up_wide[6:0] | w_up_carry_in;
    assign w_up_carry    = 7'(i_data_in >> (3'd7 - w_up_pos));

    always_comb begin
        o_entry = '0;
        o_entry.last = i_last_item;
        n_pos = r_pos;
        n_carry = r_carry;
        w_has0 = 1'b0;
        w_has1 = 1'b0;
        if (r_mode == gsp_pkg::ModePack) begin
            if (r_pos == 3'd0) begin
                n_carry = w_char;
            end else begin
                n_carry = w_pack_carry;
                w_has0 = 1'b1;
            end
            n_pos = w_pack_pos;
            // flush pending bits unless the group just closed
            w_has1 = i_last_item && (w_pack_pos != 3'd0);
            if (w_has0) begin
                o_entry.data0 = w_pack_oct;
                o_entry.data1 = {1'b0, n_carry};
                o_entry.two   = w_has1;
            end else begin
                o_entry.data0 = {1'b0, n_carry};
                o_entry.data1 = 8'd0;
                o_entry.two   = 1'b0;
            end
        end else begin
            w_has0 = 1'b1;
            o_entry.data0 = {1'b0, w_up_char};
            o_entry.data1 = {1'b0, w_up_carry};
            if (w_up_pos == gsp_pkg::PosLastUnpack) begin
                o_entry.two = 1'b1;
                n_pos = 3'd0;
                n_carry = 7'd0;
            end else begin
                o_entry.two = 1'b0;
                n_pos = w_up_pos + 3'd1;
                n_carry = w_up_carry;
            end
        end
        if (i_last_item) begin
            n_pos = 3'd0;
            n_carry = 7'd0;
        end
    end

    assign o_push = i_accept && (w_has0 || w_has1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= gsp_pkg::ModePack;
            r_pos   <= 3'd0;
            r_carry <= 7'd0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_pos   <= n_pos;
                r_carry <= n_carry;
            end
        end
    end

endmodule

@@ hdl/gsp_queue.sv @@
// Short register FIFO of result entries between front and back.
// Uses gsp_pkg for the entry type.
module gsp_queue #(
    parameter int unsigned DEPTH = gsp_pkg::QueueDepth
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  gsp_pkg::t_entry   i_entry,
    input  logic              i_pop,
    output gsp_pkg::t_entry   o_head,
    output logic              o_head_valid,
    output logic              o_full
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrMax = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

    gsp_pkg::t_entry r_mem [DEPTH];
    logic [PtrW-1:0] r_wptr;
    logic [PtrW-1:0] r_rptr;
    logic [CntW-1:0] r_count;
    logic            w_do_push;
    logic            w_do_pop;

    assign o_full       = (r_count == CntFull);
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rptr];
    assign w_do_push    = i_push && !o_full;
    assign w_do_pop     = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_wptr <= (r_wptr == PtrMax) ? '0 : r_wptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rptr <= (r_rptr == PtrMax) ? '0 : r_rptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_do_push && w_do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ hdl/gsp_back.sv @@
// Back end: drains queue entries into the output register, one result per
// cycle unless stalled, holding a 2nd result aside. Uses gsp_pkg types.
module gsp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gsp_pkg::t_entry   i_head,
    input  logic              i_head_valid,
    output logic              o_pop,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [7:0]        o_data_out,
    output logic              o_end_of_message
);

    logic       r_out_valid;
    logic [7:0] r_data;
    logic       r_eom;
    logic       r_pend_valid;
    logic [7:0] r_pend_data;
    logic       r_pend_eom;
    logic       w_load;

    assign w_load = !r_out_valid || i_out_ready;
    assign o_pop  = w_load && !r_pend_valid && i_head_valid;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_pend_valid) begin
                r_data <= r_pend_data;
                r_eom  <= r_pend_eom;
            end else begin
                r_data <= i_head.data0;
                r_eom  <= i_head.last && !i_head.two;
            end
        end
        if (o_pop) begin
            r_pend_data <= i_head.data1;
            r_pend_eom  <= i_head.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (w_load) begin
            if (r_pend_valid) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= 1'b0;
            end else begin
                r_out_valid  <= i_head_valid;
                r_pend_valid <= i_head_valid && i_head.two;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_data_out       = r_data;
    assign o_end_of_message = r_eom;

endmodule

@@ hdl/gsm_septet_pack_unpack_unit.sv @@
// Top level of the GSM 7-bit septet pack/unpack unit.
// Instantiates gsp_front, gsp_queue and gsp_back; uses gsp_pkg.
//
// Usage:
//   Input channel i_in_valid/o_in_ready carries i_data_in and i_last_item;
//   output channel o_out_valid/i_out_ready carries o_data_out and
//   o_end_of_message. i_cfg_we/i_cfg_wdata set the mode (0 pack, 1 unpack);
//   write it only while the unit is idle.
//   Path: an item's results are written into the queue when the item is
//   taken, then loaded into the output register.
//   Throughput: one item per cycle while o_in_ready is high. The output
//   register gives one result per unstalled cycle, so a two-result item
//   (pack flush or seventh unpack octet) holds the back end for its second
//   result; a continuous stream then fills the queue and o_in_ready drops.
//   Items that produce no result (first character of a pack group that is not
//   the last item) only update the front-end state.
//   Reset: mode returns to pack, group position and carry clear, queue and
//   output empty.
//   Stalls: with i_out_ready low the output holds; the queue fills and then
//   o_in_ready drops. No result is lost or repeated.
module gsm_septet_pack_unpack_unit #(
    parameter int unsigned QUEUE_DEPTH = gsp_pkg::QueueDepth
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_in,
    input  logic       i_last_item,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_data_out,
    output logic       o_end_of_message
);

    gsp_pkg::t_entry w_entry;
    gsp_pkg::t_entry w_head;
    logic            w_push;
    logic            w_pop;
    logic            w_head_valid;
    logic            w_full;
    logic            w_accept;

    assign o_in_ready = !w_full;
    assign w_accept   = i_in_valid && !w_full;

    gsp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (w_accept),
        .i_data_in   (i_data_in),
        .i_last_item (i_last_item),
        .o_push      (w_push),
        .o_entry     (w_entry)
    );

    gsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_entry      (w_entry),
        .i_pop        (w_pop),
        .o_head       (w_head),
        .o_head_valid (w_head_valid),
        .o_full       (w_full)
    );

    gsp_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (w_head),
        .i_head_valid     (w_head_valid),
        .o_pop            (w_pop),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_data_out       (o_data_out),
        .o_end_of_message (o_end_of_message)
    );

endmodule
